[design/midi_track_event_parser_defines.svh]
// Assertion macros used by the checker file of the track event parser.
`ifndef MIDI_TRACK_EVENT_PARSER_DEFINES_SVH
`define MIDI_TRACK_EVENT_PARSER_DEFINES_SVH

// General property, clocked on i_clk and off while i_rst_n is low.
`define MTEP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Property that must hold on every presented result word.
`define MTEP_ASSERT_OUT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        i_out_valid |-> (cond)) else $error(msg);

`endif

[design/mtep_pkg.sv]
// Types, codes and constants of the MIDI track event parser.
package mtep_pkg;

    // Parser phase within the track byte stream.
    typedef enum logic [3:0] {
        PH_DELTA,
        PH_STATUS,
        PH_DATA1,
        PH_DATA2,
        PH_MTYPE,
        PH_MLEN,
        PH_BODY,
        PH_SYSEX,
        PH_WAIT
    } t_phase;

    // Event kinds.
    localparam logic [3:0] KIND_NOTE_OFF   = 4'd0;
    localparam logic [3:0] KIND_NOTE_ON    = 4'd1;
    localparam logic [3:0] KIND_AFTERTOUCH = 4'd2;
    localparam logic [3:0] KIND_CONTROL    = 4'd3;
    localparam logic [3:0] KIND_PROGRAM    = 4'd4;
    localparam logic [3:0] KIND_PITCH      = 4'd5;
    localparam logic [3:0] KIND_TEMPO      = 4'd6;
    localparam logic [3:0] KIND_TRACK_END  = 4'd7;
    localparam logic [3:0] KIND_ERROR      = 4'd8;

    // Error codes.
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_LONG_VLQ  = 2'd1;
    localparam logic [1:0] ERR_TRUNCATED = 2'd2;
    localparam logic [1:0] ERR_NO_STATUS = 2'd3;

    // Status nibbles of channel messages.
    localparam logic [3:0] HI_NOTE_OFF   = 4'h8;
    localparam logic [3:0] HI_NOTE_ON    = 4'h9;
    localparam logic [3:0] HI_POLY_PRESS = 4'hA;
    localparam logic [3:0] HI_CONTROL    = 4'hB;
    localparam logic [3:0] HI_PROGRAM    = 4'hC;
    localparam logic [3:0] HI_CHAN_PRESS = 4'hD;

    // Special byte values.
    localparam logic [7:0] STATUS_SYSTEM   = 8'hF0;
    localparam logic [7:0] STATUS_SYSEX    = 8'hF0;
    localparam logic [7:0] STATUS_SONG_POS = 8'hF2;
    localparam logic [7:0] STATUS_SONG_SEL = 8'hF3;
    localparam logic [7:0] STATUS_META     = 8'hFF;
    localparam logic [7:0] SYSEX_END       = 8'hF7;
    localparam logic [7:0] META_TEMPO      = 8'h51;
    localparam logic [7:0] NO_STATUS       = 8'h00;
    localparam logic [6:0] DATA_MASK       = 7'h7F;

    localparam logic [2:0] VLQ_MAX_BYTES   = 3'd4;
    localparam logic [2:0] TEMPO_BYTES     = 3'd3;
    localparam logic [31:0] DELTA_MAX      = 32'hFFFF_FFFF;

    // Parser state carried from byte to byte.
    typedef struct packed {
        t_phase      phase;
        logic [7:0]  run_status;
        logic [7:0]  pending_status;
        logic [27:0] acc;
        logic [2:0]  qcnt;
        logic [6:0]  held;
        logic [7:0]  meta_type;
        logic [27:0] bytes_left;
        logic [23:0] tempo;
        logic [31:0] delta_sum;
        logic        error_seen;
    } t_state;

    localparam t_state STATE_RESET = '{
        phase:          PH_DELTA,
        run_status:     8'd0,
        pending_status: 8'd0,
        acc:            28'd0,
        qcnt:           3'd0,
        held:           7'd0,
        meta_type:      8'd0,
        bytes_left:     28'd0,
        tempo:          24'd0,
        delta_sum:      32'd0,
        error_seen:     1'b0
    };

    // One result word.
    typedef struct packed {
        logic [3:0]  event_kind;
        logic [3:0]  channel;
        logic [6:0]  first_data;
        logic [6:0]  second_data;
        logic [23:0] tempo_us;
        logic [31:0] delta_ticks;
        logic [1:0]  error_code;
        logic        track_done;
    } t_result;

endpackage

[design/mtep_ifs.sv]
// Valid/ready channel interfaces for track bytes and parsed events.
interface mtep_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] track_byte;
    logic       last_of_track;

    modport source (output valid, output track_byte, output last_of_track, input ready);
    modport sink   (input valid, input track_byte, input last_of_track, output ready);
endinterface

interface mtep_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  event_kind;
    logic [3:0]  channel;
    logic [6:0]  first_data;
    logic [6:0]  second_data;
    logic [23:0] tempo_us;
    logic [31:0] delta_ticks;
    logic [1:0]  error_code;
    logic        track_done;

    modport source (output valid, output event_kind, output channel, output first_data,
                    output second_data, output tempo_us, output delta_ticks,
                    output error_code, output track_done, input ready);
    modport sink   (input valid, input event_kind, input channel, input first_data,
                    input second_data, input tempo_us, input delta_ticks,
                    input error_code, input track_done, output ready);
endinterface

[design/mtep_step.sv]
// Combinational next-state and result logic for one track byte.
module mtep_step (
    input  mtep_pkg::t_state  i_state,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    output mtep_pkg::t_state  o_state,
    output logic              o_emit,
    output mtep_pkg::t_result o_result
);

    mtep_pkg::t_state  s;
    mtep_pkg::t_result res;
    logic              emit;
    logic [6:0]        d;
    logic [27:0]       vlq_acc;
    logic [32:0]       sum;
    logic [27:0]       left_dec;
    logic [23:0]       tempo_next;
    logic              do_fail;
    logic [1:0]        fail_code;
    logic              do_first;
    logic              do_chan;
    logic [6:0]        chan_d1;
    logic [6:0]        chan_d2;
    logic              do_tempo;
    logic [23:0]       tempo_val;
    logic [3:0]        hi;
    logic [3:0]        kind;

    assign d       = i_byte[6:0] & mtep_pkg::DATA_MASK;
    assign vlq_acc = {i_state.acc[20:0], d};
    assign sum     = {1'b0, i_state.delta_sum} + {5'd0, vlq_acc};

    always_comb begin
        s          = i_state;
        res        = '0;
        emit       = 1'b0;
        do_fail    = 1'b0;
        fail_code  = mtep_pkg::ERR_NONE;
        do_first   = 1'b0;
        do_chan    = 1'b0;
        chan_d1    = 7'd0;
        chan_d2    = 7'd0;
        do_tempo   = 1'b0;
        tempo_val  = 24'd0;
        left_dec   = i_state.bytes_left - 28'd1;
        tempo_next = i_state.tempo;
        hi         = 4'd0;
        kind       = mtep_pkg::KIND_PITCH;

        // Per-phase handling of the byte.
        case (i_state.phase)
            mtep_pkg::PH_DELTA: begin
                if (i_state.qcnt >= mtep_pkg::VLQ_MAX_BYTES) begin
                    do_fail   = 1'b1;
                    fail_code = mtep_pkg::ERR_LONG_VLQ;
                end else begin
                    s.acc  = vlq_acc;
                    s.qcnt = i_state.qcnt + 3'd1;
                    if (!i_byte[7]) begin
                        s.delta_sum = sum[32] ? mtep_pkg::DELTA_MAX : sum[31:0];
                        s.phase     = mtep_pkg::PH_STATUS;
                    end
                end
            end
            mtep_pkg::PH_STATUS: begin
                if (i_byte[7]) begin
                    if (i_byte < mtep_pkg::STATUS_SYSTEM) begin
                        s.run_status     = i_byte;
                        s.pending_status = i_byte;
                        s.phase          = mtep_pkg::PH_DATA1;
                    end else if (i_byte == mtep_pkg::STATUS_META) begin
                        s.phase = mtep_pkg::PH_MTYPE;
                    end else if (i_byte == mtep_pkg::STATUS_SYSEX) begin
                        s.phase = mtep_pkg::PH_SYSEX;
                    end else if (i_byte inside {mtep_pkg::STATUS_SONG_POS,
                                                mtep_pkg::STATUS_SONG_SEL}) begin
                        s.meta_type  = 8'd0;
                        s.bytes_left = (i_byte == mtep_pkg::STATUS_SONG_POS) ? 28'd2 : 28'd1;
                        s.qcnt       = 3'd0;
                        s.tempo      = 24'd0;
                        s.phase      = mtep_pkg::PH_BODY;
                    end else begin
                        s.phase = mtep_pkg::PH_DELTA;
                        s.acc   = 28'd0;
                        s.qcnt  = 3'd0;
                    end
                end else if (i_state.run_status == mtep_pkg::NO_STATUS) begin
                    do_fail   = 1'b1;
                    fail_code = mtep_pkg::ERR_NO_STATUS;
                end else begin
                    s.pending_status = i_state.run_status;
                    do_first         = 1'b1;
                end
            end
            mtep_pkg::PH_DATA1: begin
                do_first = 1'b1;
            end
            mtep_pkg::PH_DATA2: begin
                do_chan = 1'b1;
                chan_d1 = i_state.held;
                chan_d2 = d;
            end
            mtep_pkg::PH_MTYPE: begin
                s.meta_type = i_byte;
                s.acc       = 28'd0;
                s.qcnt      = 3'd0;
                s.phase     = mtep_pkg::PH_MLEN;
            end
            mtep_pkg::PH_MLEN: begin
                if (i_state.qcnt >= mtep_pkg::VLQ_MAX_BYTES) begin
                    do_fail   = 1'b1;
                    fail_code = mtep_pkg::ERR_LONG_VLQ;
                end else begin
                    s.acc  = vlq_acc;
                    s.qcnt = i_state.qcnt + 3'd1;
                    if (!i_byte[7]) begin
                        if (vlq_acc == 28'd0) begin
                            do_tempo = (i_state.meta_type == mtep_pkg::META_TEMPO);
                            s.phase  = mtep_pkg::PH_DELTA;
                            s.acc    = 28'd0;
                            s.qcnt   = 3'd0;
                        end else begin
                            s.bytes_left = vlq_acc;
                            s.qcnt       = 3'd0;
                            s.tempo      = 24'd0;
                            s.phase      = mtep_pkg::PH_BODY;
                        end
                    end
                end
            end
            mtep_pkg::PH_BODY: begin
                // The first three bytes of a tempo body form the tempo value.
                if (i_state.meta_type == mtep_pkg::META_TEMPO &&
                    i_state.qcnt < mtep_pkg::TEMPO_BYTES) begin
                    tempo_next = {i_state.tempo[15:0], i_byte};
                    s.qcnt     = i_state.qcnt + 3'd1;
                end
                s.tempo      = tempo_next;
                s.bytes_left = left_dec;
                if (left_dec == 28'd0) begin
                    do_tempo  = (i_state.meta_type == mtep_pkg::META_TEMPO);
                    tempo_val = tempo_next;
                    s.phase   = mtep_pkg::PH_DELTA;
                    s.acc     = 28'd0;
                    s.qcnt    = 3'd0;
                end
            end
            mtep_pkg::PH_SYSEX: begin
                if (i_byte == mtep_pkg::SYSEX_END) begin
                    s.phase = mtep_pkg::PH_DELTA;
                    s.acc   = 28'd0;
                    s.qcnt  = 3'd0;
                end
            end
            default: begin
            end
        endcase

        // First data byte: one-byte messages complete here.
        hi = s.pending_status[7:4];
        if (do_first) begin
            s.held = d;
            if (hi inside {mtep_pkg::HI_PROGRAM, mtep_pkg::HI_CHAN_PRESS}) begin
                do_chan = 1'b1;
                chan_d1 = d;
                chan_d2 = 7'd0;
            end else begin
                s.phase = mtep_pkg::PH_DATA2;
            end
        end

        // Channel message kind from the status nibble.
        case (hi)
            mtep_pkg::HI_NOTE_OFF:   kind = mtep_pkg::KIND_NOTE_OFF;
            mtep_pkg::HI_NOTE_ON:    kind = (chan_d2 != 7'd0) ? mtep_pkg::KIND_NOTE_ON
                                                              : mtep_pkg::KIND_NOTE_OFF;
            mtep_pkg::HI_POLY_PRESS: kind = mtep_pkg::KIND_AFTERTOUCH;
            mtep_pkg::HI_CONTROL:    kind = mtep_pkg::KIND_CONTROL;
            mtep_pkg::HI_PROGRAM:    kind = mtep_pkg::KIND_PROGRAM;
            mtep_pkg::HI_CHAN_PRESS: kind = mtep_pkg::KIND_AFTERTOUCH;
            default:                 kind = mtep_pkg::KIND_PITCH;
        endcase

        // Build the result word; each result restarts the delta sum.
        res.delta_ticks = s.delta_sum;
        if (do_fail) begin
            res.event_kind = mtep_pkg::KIND_ERROR;
            res.error_code = fail_code;
            s.error_seen   = 1'b1;
            s.phase        = mtep_pkg::PH_WAIT;
            emit           = 1'b1;
        end else if (do_chan) begin
            res.event_kind  = kind;
            res.channel     = s.pending_status[3:0];
            res.first_data  = chan_d1;
            res.second_data = chan_d2;
            s.phase         = mtep_pkg::PH_DELTA;
            s.acc           = 28'd0;
            s.qcnt          = 3'd0;
            emit            = 1'b1;
        end else if (do_tempo) begin
            res.event_kind = mtep_pkg::KIND_TEMPO;
            res.tempo_us   = tempo_val;
            emit           = 1'b1;
        end
        if (emit) begin
            s.delta_sum = 32'd0;
        end

        // The last byte of a track always gives a result and clears the state.
        if (i_last) begin
            if (!emit) begin
                res             = '0;
                res.delta_ticks = s.delta_sum;
                if (s.error_seen || (s.phase == mtep_pkg::PH_DELTA && s.qcnt == 3'd0)) begin
                    res.event_kind = mtep_pkg::KIND_TRACK_END;
                end else begin
                    res.event_kind = mtep_pkg::KIND_ERROR;
                    res.error_code = mtep_pkg::ERR_TRUNCATED;
                end
            end
            res.track_done = 1'b1;
            emit           = 1'b1;
            s              = mtep_pkg::STATE_RESET;
        end
    end

    assign o_state  = s;
    assign o_emit   = emit;
    assign o_result = res;

endmodule

[design/mtep_out_buf.sv]
// Two-entry result buffer: an output register backed by a skid register.
module mtep_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mtep_pkg::t_result i_data,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_ready,
    output mtep_pkg::t_result o_data
);

    logic              r_out_valid;
    logic              n_out_valid;
    mtep_pkg::t_result r_out;
    mtep_pkg::t_result n_out;
    logic              r_skid_valid;
    logic              n_skid_valid;
    mtep_pkg::t_result r_skid;
    mtep_pkg::t_result n_skid;
    logic              take;

    assign take = r_out_valid && i_ready;

    // Refill the output register from the skid register first, then from a new word.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            if (take) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || take) begin
                n_out       = i_data;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = i_data;
                n_skid_valid = 1'b1;
            end
        end else if (take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

[design/midi_track_event_parser.sv]
// Top level of the MIDI track event parser.
//
// Usage: i_in carries one track byte per word, starting at the first delta
// time of a track chunk body, with last_of_track set on the final byte.
// o_out carries parsed events: channel messages, tempo meta events, a track
// end marker and errors, each with the ticks summed since the last event.
// The event a byte completes is loaded into the output register, or the skid
// register if o_out stalls. One byte is taken per cycle while the skid
// register is empty; one state register, updated by one logic pass per byte.
// The output side is a two-word buffer (output register plus skid register).
// When the receiver stalls, bytes are still taken until both words are full;
// i_in.ready drops only while the skid register holds a word.
// Reset (synchronous, i_rst_n low) clears the parser to expect a delta time
// with no running status and empties the output buffer. The last byte of a
// track also returns the parser to that state for the next track.
module midi_track_event_parser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    mtep_in_if.sink         i_in,
    mtep_out_if.source      o_out
);

    mtep_pkg::t_state  r_state;
    mtep_pkg::t_state  n_state;
    logic              step_emit;
    mtep_pkg::t_result step_result;
    mtep_pkg::t_result out_word;
    logic              buf_full;
    logic              accept;

    assign i_in.ready = !buf_full;
    assign accept     = i_in.valid && !buf_full;

    // Next state and result for the byte on the input.
    mtep_step u_step (
        .i_state  (r_state),
        .i_byte   (i_in.track_byte),
        .i_last   (i_in.last_of_track),
        .o_state  (n_state),
        .o_emit   (step_emit),
        .o_result (step_result)
    );

    // Parser state advances on every accepted word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mtep_pkg::STATE_RESET;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    mtep_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept && step_emit),
        .i_data  (step_result),
        .o_full  (buf_full),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_data  (out_word)
    );

    assign o_out.event_kind  = out_word.event_kind;
    assign o_out.channel     = out_word.channel;
    assign o_out.first_data  = out_word.first_data;
    assign o_out.second_data = out_word.second_data;
    assign o_out.tempo_us    = out_word.tempo_us;
    assign o_out.delta_ticks = out_word.delta_ticks;
    assign o_out.error_code  = out_word.error_code;
    assign o_out.track_done  = out_word.track_done;

endmodule

[design/mtep_checker.sv]
// Port-level checker for the MIDI track event parser, bound to the top level.
`include "midi_track_event_parser_defines.svh"

module mtep_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [3:0] i_event_kind,
    input logic [1:0] i_error_code,
    input logic       i_track_done
);

    // A presented word stays until it is taken.
    `MTEP_ASSERT(a_stall_hold, i_out_valid && !i_out_ready |=> i_out_valid, "result word dropped while stalled")

    // The input only stalls when a result word is waiting.
    `MTEP_ASSERT(a_busy_has_word, !i_in_ready |-> i_out_valid, "input stalled with no word pending")

    // Error words carry a code, other words do not.
    `MTEP_ASSERT_OUT(a_error_coded, i_event_kind != mtep_pkg::KIND_ERROR || i_error_code != mtep_pkg::ERR_NONE, "error word without error code")
    `MTEP_ASSERT_OUT(a_clean_code, i_event_kind == mtep_pkg::KIND_ERROR || i_error_code == mtep_pkg::ERR_NONE, "error code on a non-error word")

    // A bare track end marker only comes with the last byte.
    `MTEP_ASSERT_OUT(a_end_done, i_event_kind != mtep_pkg::KIND_TRACK_END || i_track_done, "track end marker without track_done")

endmodule

bind midi_track_event_parser mtep_checker u_mtep_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_event_kind (o_out.event_kind),
    .i_error_code (o_out.error_code),
    .i_track_done (o_out.track_done)
);
